// ===== sv/mbrv_pkg.sv =====
package mbrv_pkg;

  localparam int unsigned CAP_DEFAULT = 256;
  localparam int unsigned CAP_W       = 17;
  localparam int unsigned CFG_ADDR_W  = 5;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FUNC  = 2'd1,
    ST_BAD_ADDR  = 2'd2,
    ST_BAD_VALUE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_COIL_BASE     = 3'd0,
    REG_COIL_SPAN     = 3'd1,
    REG_DISCRETE_BASE = 3'd2,
    REG_DISCRETE_SPAN = 3'd3,
    REG_HOLDING_BASE  = 3'd4,
    REG_HOLDING_SPAN  = 3'd5,
    REG_INREG_BASE    = 3'd6,
    REG_INREG_SPAN    = 3'd7
  } reg_idx_t;

  localparam logic [7:0] FC_READ_COILS        = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE     = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING      = 8'd3;
  localparam logic [7:0] FC_READ_INREG        = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL        = 8'd5;
  localparam logic [7:0] FC_WRITE_REG         = 8'd6;
  localparam logic [7:0] FC_WRITE_MULTI_COILS = 8'd15;
  localparam logic [7:0] FC_WRITE_MULTI_REGS  = 8'd16;

  localparam logic [15:0] COIL_ON  = 16'hFF00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

endpackage

// ===== sv/mbrv_if.sv =====
interface mbrv_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fn_code;
  logic [15:0] req_addr;
  logic [15:0] count_or_value;

  modport source (output valid, output fn_code, output req_addr,
                  output count_or_value, input ready);
  modport sink   (input valid, input fn_code, input req_addr,
                  input count_or_value, output ready);
endinterface

interface mbrv_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink   (input valid, input status, output ready);
endinterface

// ===== sv/modbus_request_validator.sv =====
// Channel   Dir  Handshake                 Payload
// in_req    in   valid/ready               fn_code, req_addr, count_or_value
// out_rsp   out  valid/ready               status
// cfg_*     in   APB, pready tied high     8 x 16-bit region registers at 4*i
//
// One request per cycle sustained while out_rsp.ready stays high; out_rsp.valid follows
// acceptance through the input register, then the status register.
// A stalled status holds in its register while the input register keeps
// filling; in_req.ready drops only when both stages are full.
// rst_n is synchronous; it clears the stage valids and all region registers.
module modbus_request_validator #(
  parameter int unsigned COIL_CAPACITY     = mbrv_pkg::CAP_DEFAULT,
  parameter int unsigned DISCRETE_CAPACITY = mbrv_pkg::CAP_DEFAULT,
  parameter int unsigned HOLDING_CAPACITY  = mbrv_pkg::CAP_DEFAULT,
  parameter int unsigned INREG_CAPACITY    = mbrv_pkg::CAP_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  mbrv_req_if.sink                          in_req,
  mbrv_rsp_if.source                        out_rsp,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [mbrv_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [mbrv_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [mbrv_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam logic [mbrv_pkg::CAP_W-1:0] COIL_CAP17     = mbrv_pkg::CAP_W'(COIL_CAPACITY);
  localparam logic [mbrv_pkg::CAP_W-1:0] DISCRETE_CAP17 = mbrv_pkg::CAP_W'(DISCRETE_CAPACITY);
  localparam logic [mbrv_pkg::CAP_W-1:0] HOLDING_CAP17  = mbrv_pkg::CAP_W'(HOLDING_CAPACITY);
  localparam logic [mbrv_pkg::CAP_W-1:0] INREG_CAP17    = mbrv_pkg::CAP_W'(INREG_CAPACITY);

  logic [15:0] coil_base_r, coil_span_r, discrete_base_r, discrete_span_r;
  logic [15:0] holding_base_r, holding_span_r, inreg_base_r, inreg_span_r;

  logic                cfg_wr;
  mbrv_pkg::reg_idx_t  cfg_idx;

  logic        s1_valid_r;
  logic [7:0]  fc_r;
  logic [15:0] start_r;
  logic [15:0] word_r;

  logic                s2_valid_r;
  mbrv_pkg::status_t   status_r;
  mbrv_pkg::status_t   status_nxt;

  logic s2_ready;
  logic s1_ready;

  logic [15:0]                 base;
  logic [15:0]                 span;
  logic [mbrv_pkg::CAP_W-1:0]  cap;
  logic [15:0]                 qty;
  logic                        fc_known;
  logic                        lo_ok, hi_ok, qty_ok;
  logic [15:0]                 offset;
  logic [mbrv_pkg::CAP_W-1:0]  qty17;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = mbrv_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coil_base_r     <= '0;
      coil_span_r     <= '0;
      discrete_base_r <= '0;
      discrete_span_r <= '0;
      holding_base_r  <= '0;
      holding_span_r  <= '0;
      inreg_base_r    <= '0;
      inreg_span_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        mbrv_pkg::REG_COIL_BASE:     coil_base_r     <= cfg_pwdata[15:0];
        mbrv_pkg::REG_COIL_SPAN:     coil_span_r     <= cfg_pwdata[15:0];
        mbrv_pkg::REG_DISCRETE_BASE: discrete_base_r <= cfg_pwdata[15:0];
        mbrv_pkg::REG_DISCRETE_SPAN: discrete_span_r <= cfg_pwdata[15:0];
        mbrv_pkg::REG_HOLDING_BASE:  holding_base_r  <= cfg_pwdata[15:0];
        mbrv_pkg::REG_HOLDING_SPAN:  holding_span_r  <= cfg_pwdata[15:0];
        mbrv_pkg::REG_INREG_BASE:    inreg_base_r    <= cfg_pwdata[15:0];
        mbrv_pkg::REG_INREG_SPAN:    inreg_span_r    <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_idx)
      mbrv_pkg::REG_COIL_BASE:     cfg_prdata[15:0] = coil_base_r;
      mbrv_pkg::REG_COIL_SPAN:     cfg_prdata[15:0] = coil_span_r;
      mbrv_pkg::REG_DISCRETE_BASE: cfg_prdata[15:0] = discrete_base_r;
      mbrv_pkg::REG_DISCRETE_SPAN: cfg_prdata[15:0] = discrete_span_r;
      mbrv_pkg::REG_HOLDING_BASE:  cfg_prdata[15:0] = holding_base_r;
      mbrv_pkg::REG_HOLDING_SPAN:  cfg_prdata[15:0] = holding_span_r;
      mbrv_pkg::REG_INREG_BASE:    cfg_prdata[15:0] = inreg_base_r;
      mbrv_pkg::REG_INREG_SPAN:    cfg_prdata[15:0] = inreg_span_r;
      default:                     cfg_prdata = '0;
    endcase
  end

  // pipeline control
  assign s2_ready     = !s2_valid_r || out_rsp.ready;
  assign s1_ready     = !s1_valid_r || s2_ready;
  assign in_req.ready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_req.valid) begin
      fc_r    <= in_req.fn_code;
      start_r <= in_req.req_addr;
      word_r  <= in_req.count_or_value;
    end
  end

  // region select
  always_comb begin
    fc_known = 1'b1;
    base     = coil_base_r;
    span     = coil_span_r;
    cap      = COIL_CAP17;
    qty      = word_r;
    unique case (fc_r) inside
      mbrv_pkg::FC_READ_COILS, mbrv_pkg::FC_WRITE_MULTI_COILS: begin
        base = coil_base_r;
        span = coil_span_r;
        cap  = COIL_CAP17;
      end
      mbrv_pkg::FC_WRITE_COIL: begin
        base = coil_base_r;
        span = coil_span_r;
        cap  = COIL_CAP17;
        qty  = 16'd1;
      end
      mbrv_pkg::FC_READ_DISCRETE: begin
        base = discrete_base_r;
        span = discrete_span_r;
        cap  = DISCRETE_CAP17;
      end
      mbrv_pkg::FC_READ_HOLDING, mbrv_pkg::FC_WRITE_MULTI_REGS: begin
        base = holding_base_r;
        span = holding_span_r;
        cap  = HOLDING_CAP17;
      end
      mbrv_pkg::FC_WRITE_REG: begin
        base = holding_base_r;
        span = holding_span_r;
        cap  = HOLDING_CAP17;
        qty  = 16'd1;
      end
      mbrv_pkg::FC_READ_INREG: begin
        base = inreg_base_r;
        span = inreg_span_r;
        cap  = INREG_CAP17;
      end
      default: fc_known = 1'b0;
    endcase
  end

  // range checks, 17-bit sums
  assign lo_ok  = start_r >= base;
  assign hi_ok  = {1'b0, start_r} < ({1'b0, base} + {1'b0, span});
  assign offset = start_r - base;
  assign qty17  = {1'b0, qty};
  assign qty_ok = (qty != 16'd0) && (qty17 <= cap) && ((qty17 + {1'b0, offset}) <= cap);

  always_comb begin
    if (!fc_known) begin
      status_nxt = mbrv_pkg::ST_BAD_FUNC;
    end else if (!(lo_ok && hi_ok && qty_ok)) begin
      status_nxt = mbrv_pkg::ST_BAD_ADDR;
    end else if (fc_r == mbrv_pkg::FC_WRITE_COIL && word_r != mbrv_pkg::COIL_ON
                 && word_r != mbrv_pkg::COIL_OFF) begin
      status_nxt = mbrv_pkg::ST_BAD_VALUE;
    end else begin
      status_nxt = mbrv_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      status_r <= status_nxt;
    end
  end

  assign out_rsp.valid  = s2_valid_r;
  assign out_rsp.status = status_r;

endmodule
